>>> rtl/core/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit
// request payload structs, operation and status codes, controller states
// no dependencies
`timescale 1ns / 1ps

package rau_pkg;

  localparam int FIELD_BITS = 64;

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_MUL = 2'd1,
    FN_CMP = 2'd2,
    FN_INT = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } order_e_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OVF  = 2'd1,
    STAT_ZDEN = 2'd2
  } status_e_t;

  typedef struct packed {
    func_e_t                func;
    logic [FIELD_BITS-1:0]  a_num;
    logic [FIELD_BITS-1:0]  a_den;
    logic                   a_neg;
    logic [FIELD_BITS-1:0]  b_num;
    logic [FIELD_BITS-1:0]  b_den;
    logic                   b_neg;
  } in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0]         r_num;
    logic [FIELD_BITS-1:0]         r_den;
    logic                          r_neg;
    order_e_t                      order;
    logic signed [FIELD_BITS-1:0]  int_value;
    status_e_t                     status;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INT_DIV,
    ST_CMP_M1,
    ST_CMP_M2,
    ST_MUL_M1,
    ST_MUL_M2,
    ST_ADD_G,
    ST_ADD_D1,
    ST_ADD_M1,
    ST_ADD_D2,
    ST_ADD_M2,
    ST_ADD_D3,
    ST_ADD_M3,
    ST_ADD_SUM,
    ST_RED_G,
    ST_RED_D1,
    ST_RED_D2,
    ST_FINISH
  } state_e_t;

  typedef struct packed {
    state_e_t step;
    logic     go;
    logic     load_in;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic    done;
    logic    ovf;
    logic    zden;
    func_e_t func;
  } sts_t;

endpackage

>>> rtl/core/rational_arithmetic_unit.sv
// One request at a time. To integer is one division; compare is two multiplies; multiply is
// two multiplies, a gcd run and two divisions; add is a gcd run, three divisions and three
// multiplies, a signed sum, then a gcd run and two divisions. The divider, shift-add multiplier
// and one-step-per-cycle binary gcd are shared by all steps.
// A new request is taken once the previous result sits in the output register.
// Synchronous reset (rst_n) clears the sequencer, output valid flag and unit busy/done flags.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rau_pkg::out_t out_data
);

  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp #(.W(WORD_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .sts     (sts),
    .out_data(out_data)
  );

  a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_OK) |->
      (out_data.r_num == '0 && out_data.r_den == '0 && out_data.int_value == '0 &&
       out_data.order == ORD_LT && !out_data.r_neg))
    else $error("error result carries data");

  a_den_only_arith: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.r_den != '0) |->
      (out_data.status == STAT_OK && out_data.int_value == '0 && out_data.order == ORD_LT))
    else $error("reduced fraction mixed with other results");

  a_zero_canon: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.r_num == '0 && out_data.r_den != '0) |->
      (out_data.r_den == 1 && !out_data.r_neg))
    else $error("zero result not canonical");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

endmodule

>>> rtl/core/rau_div.sv
// rau_div: restoring divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps

module rau_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dvd,
  input  logic [W-1:0] dvs,
  output logic         done,
  output logic [W-1:0] quot
);

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    trial    = {rem_r, quo_r[W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      rem_nxt  = '0;
      quo_nxt  = dvd;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> rtl/core/rau_mul.sv
// rau_mul: shift-add multiplier, one multiplier bit per cycle, full product
// depends on nothing
`timescale 1ns / 1ps

module rau_mul #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [2*W-1:0] prod_r, prod_nxt;
  logic [W-1:0]   mc_r, mc_nxt;
  logic [W:0]     sum;
  logic [2*W:0]   shifted;

  always_comb begin
    sum      = {1'b0, prod_r[2*W-1:W]} + (prod_r[0] ? {1'b0, mc_r} : '0);
    shifted  = {sum, prod_r[W-1:0]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    mc_nxt   = mc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      prod_nxt = {{W{1'b0}}, b};
      mc_nxt   = a;
    end else if (busy_r) begin
      prod_nxt = shifted[2*W:1];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    mc_r   <= mc_nxt;
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

>>> rtl/core/rau_dp.sv
// rau_dp: operand and result registers, binary gcd, operand routing
// depends on rau_pkg, rau_div, rau_mul
`timescale 1ns / 1ps

module rau_dp #(
  parameter int W = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rau_pkg::cmd_t cmd,
  input  rau_pkg::in_t  in_data,
  output rau_pkg::sts_t sts,
  output rau_pkg::out_t out_data
);

  import rau_pkg::*;

  localparam int KW = $clog2(W);

  func_e_t   func_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic      aneg_r, bneg_r;
  logic [W-1:0] g_r, tq_r, num_r, den_r, sa_r, sb_r;
  logic      neg_r;
  logic [2*W-1:0] p1_r;
  logic [W-1:0] rn_r, rd_r, ival_r;
  logic      rneg_r;
  order_e_t  ord_r;
  status_e_t st_r;
  out_t      out_r;

  // gcd unit
  logic [W-1:0]  gx_r, gy_r;
  logic [KW-1:0] gk_r;
  logic          gbusy_r, gdone_r;
  logic          gcd_start;
  logic [W-1:0]  gcd_x, gcd_y;

  // shared units
  logic           mul_start, mul_done, div_start, div_done;
  logic [W-1:0]   mul_a, mul_b, div_n, div_d;
  logic [2*W-1:0] mul_prod;
  logic [W-1:0]   quot;

  logic           unit_done, ovf_now, zden;
  logic [W-1:0]   q_neg;
  logic           int_ovf;
  logic [W:0]     sum_w;
  logic           same_sign, b_bigger;
  logic [W-1:0]   sum_num;
  logic           sum_neg;
  logic           za, zb, sga, sgb, mlt, meq;
  order_e_t       ord_calc;

  rau_mul #(.W(W)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  rau_div #(.W(W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .dvd  (div_n),
    .dvs  (div_d),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    gcd_start = 1'b0;
    mul_a = an_r;
    mul_b = bn_r;
    div_n = an_r;
    div_d = ad_r;
    gcd_x = ad_r;
    gcd_y = bd_r;
    case (cmd.step)
      ST_CMP_M1: begin mul_start = cmd.go; mul_a = an_r; mul_b = bd_r; end
      ST_CMP_M2: begin mul_start = cmd.go; mul_a = bn_r; mul_b = ad_r; end
      ST_MUL_M1: begin mul_start = cmd.go; mul_a = an_r; mul_b = bn_r; end
      ST_MUL_M2: begin mul_start = cmd.go; mul_a = ad_r; mul_b = bd_r; end
      ST_ADD_M1: begin mul_start = cmd.go; mul_a = tq_r; mul_b = bd_r; end
      ST_ADD_M2: begin mul_start = cmd.go; mul_a = an_r; mul_b = tq_r; end
      ST_ADD_M3: begin mul_start = cmd.go; mul_a = bn_r; mul_b = tq_r; end
      ST_INT_DIV: begin div_start = cmd.go; div_n = an_r; div_d = ad_r; end
      ST_ADD_D1: begin div_start = cmd.go; div_n = ad_r; div_d = g_r; end
      ST_ADD_D2: begin div_start = cmd.go; div_n = den_r; div_d = ad_r; end
      ST_ADD_D3: begin div_start = cmd.go; div_n = den_r; div_d = bd_r; end
      ST_RED_D1: begin div_start = cmd.go; div_n = num_r; div_d = g_r; end
      ST_RED_D2: begin div_start = cmd.go; div_n = den_r; div_d = g_r; end
      ST_ADD_G: begin gcd_start = cmd.go; gcd_x = ad_r; gcd_y = bd_r; end
      ST_RED_G: begin gcd_start = cmd.go; gcd_x = num_r; gcd_y = den_r; end
      default: ;
    endcase
  end

  // binary gcd, one step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbusy_r <= 1'b0;
      gdone_r <= 1'b0;
    end else begin
      gdone_r <= 1'b0;
      if (gcd_start) begin
        gbusy_r <= 1'b1;
      end else if (gbusy_r && (gx_r == '0 || gy_r == '0)) begin
        gbusy_r <= 1'b0;
        gdone_r <= 1'b1;
      end
    end
    if (gcd_start) begin
      gx_r <= gcd_x;
      gy_r <= gcd_y;
      gk_r <= '0;
    end else if (gbusy_r) begin
      priority if (gx_r == '0 || gy_r == '0) begin
        g_r <= (gx_r | gy_r) << gk_r;
      end else if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        gk_r <= gk_r + 1'b1;
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (gx_r >= gy_r) begin
        gx_r <= gx_r - gy_r;
      end else begin
        gy_r <= gy_r - gx_r;
      end
    end
  end

  always_comb begin
    unit_done = mul_done | div_done | gdone_r;
    zden      = (func_r == FN_INT) ? (ad_r == '0) : (ad_r == '0 || bd_r == '0);
    q_neg     = '0 - quot;
    int_ovf   = aneg_r ? (quot[W-1] && quot[W-2:0] != '0) : quot[W-1];
    same_sign = aneg_r == bneg_r;
    sum_w     = {1'b0, sa_r} + {1'b0, sb_r};
    b_bigger  = sb_r > sa_r;
    if (same_sign) begin
      sum_num = sum_w[W-1:0];
      sum_neg = aneg_r;
    end else if (b_bigger) begin
      sum_num = sb_r - sa_r;
      sum_neg = bneg_r;
    end else begin
      sum_num = sa_r - sb_r;
      sum_neg = aneg_r;
    end
    za  = an_r == '0;
    zb  = bn_r == '0;
    sga = aneg_r && !za;
    sgb = bneg_r && !zb;
    mlt = p1_r < mul_prod;
    meq = p1_r == mul_prod;
    if (za && zb) begin
      ord_calc = ORD_EQ;
    end else if (sga != sgb) begin
      ord_calc = sga ? ORD_LT : ORD_GT;
    end else if (meq) begin
      ord_calc = ORD_EQ;
    end else if (mlt != sga) begin
      ord_calc = ORD_LT;
    end else begin
      ord_calc = ORD_GT;
    end
    case (cmd.step)
      ST_MUL_M1, ST_MUL_M2, ST_ADD_M1, ST_ADD_M2, ST_ADD_M3:
        ovf_now = mul_prod[2*W-1:W] != '0;
      ST_INT_DIV: ovf_now = int_ovf;
      ST_ADD_SUM: ovf_now = same_sign && sum_w[W];
      default:    ovf_now = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_data.func;
      an_r   <= in_data.a_num[W-1:0];
      ad_r   <= in_data.a_den[W-1:0];
      aneg_r <= in_data.a_neg;
      bn_r   <= in_data.b_num[W-1:0];
      bd_r   <= in_data.b_den[W-1:0];
      bneg_r <= in_data.b_neg;
    end
    if (cmd.step == ST_CHECK) begin
      rn_r   <= '0;
      rd_r   <= '0;
      rneg_r <= 1'b0;
      ord_r  <= ORD_LT;
      ival_r <= '0;
      st_r   <= zden ? STAT_ZDEN : STAT_OK;
    end
    if (cmd.step == ST_ADD_SUM) begin
      num_r <= sum_num;
      neg_r <= sum_neg;
      if (ovf_now) st_r <= STAT_OVF;
    end
    if (unit_done) begin
      if (ovf_now) st_r <= STAT_OVF;
      case (cmd.step)
        ST_INT_DIV: if (!int_ovf) ival_r <= aneg_r ? q_neg : quot;
        ST_CMP_M1:  p1_r <= mul_prod;
        ST_CMP_M2:  ord_r <= ord_calc;
        ST_MUL_M1:  num_r <= mul_prod[W-1:0];
        ST_MUL_M2: begin
          den_r <= mul_prod[W-1:0];
          neg_r <= aneg_r ^ bneg_r;
        end
        ST_ADD_D1:  tq_r <= quot;
        ST_ADD_M1:  den_r <= mul_prod[W-1:0];
        ST_ADD_D2:  tq_r <= quot;
        ST_ADD_M2:  sa_r <= mul_prod[W-1:0];
        ST_ADD_D3:  tq_r <= quot;
        ST_ADD_M3:  sb_r <= mul_prod[W-1:0];
        ST_RED_D1:  rn_r <= quot;
        ST_RED_D2: begin
          rd_r   <= quot;
          rneg_r <= neg_r && rn_r != '0;
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_r.r_num     <= FIELD_BITS'(rn_r);
      out_r.r_den     <= FIELD_BITS'(rd_r);
      out_r.r_neg     <= rneg_r;
      out_r.order     <= ord_r;
      out_r.int_value <= FIELD_BITS'(signed'(ival_r));
      out_r.status    <= st_r;
    end
  end

  assign sts.done = unit_done;
  assign sts.ovf  = ovf_now;
  assign sts.zden = zden;
  assign sts.func = func_r;
  assign out_data = out_r;

endmodule

>>> rtl/core/rau_ctrl.sv
// rau_ctrl: sequencer for one request at a time, output valid flag
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);

  import rau_pkg::*;

  state_e_t state_r, state_nxt;
  logic     go_r, go_nxt;
  logic     ov_r, ov_nxt;
  logic     load_out;

  // advance on unit completion, bail out to finish on overflow
  function automatic state_e_t after_unit(state_e_t cur, state_e_t nxt, logic done,
                                          logic ovf);
    state_e_t s;
    s = cur;
    if (done) begin
      s = ovf ? ST_FINISH : nxt;
    end
    return s;
  endfunction

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.zden) begin
          state_nxt = ST_FINISH;
        end else begin
          unique case (sts.func)
            FN_INT: state_nxt = ST_INT_DIV;
            FN_CMP: state_nxt = ST_CMP_M1;
            FN_MUL: state_nxt = ST_MUL_M1;
            FN_ADD: state_nxt = ST_ADD_G;
          endcase
        end
      end
      ST_INT_DIV: state_nxt = after_unit(state_r, ST_FINISH, sts.done, sts.ovf);
      ST_CMP_M1:  state_nxt = after_unit(state_r, ST_CMP_M2, sts.done, sts.ovf);
      ST_CMP_M2:  state_nxt = after_unit(state_r, ST_FINISH, sts.done, sts.ovf);
      ST_MUL_M1:  state_nxt = after_unit(state_r, ST_MUL_M2, sts.done, sts.ovf);
      ST_MUL_M2:  state_nxt = after_unit(state_r, ST_RED_G, sts.done, sts.ovf);
      ST_ADD_G:   state_nxt = after_unit(state_r, ST_ADD_D1, sts.done, sts.ovf);
      ST_ADD_D1:  state_nxt = after_unit(state_r, ST_ADD_M1, sts.done, sts.ovf);
      ST_ADD_M1:  state_nxt = after_unit(state_r, ST_ADD_D2, sts.done, sts.ovf);
      ST_ADD_D2:  state_nxt = after_unit(state_r, ST_ADD_M2, sts.done, sts.ovf);
      ST_ADD_M2:  state_nxt = after_unit(state_r, ST_ADD_D3, sts.done, sts.ovf);
      ST_ADD_D3:  state_nxt = after_unit(state_r, ST_ADD_M3, sts.done, sts.ovf);
      ST_ADD_M3:  state_nxt = after_unit(state_r, ST_ADD_SUM, sts.done, sts.ovf);
      ST_ADD_SUM: state_nxt = sts.ovf ? ST_FINISH : ST_RED_G;
      ST_RED_G:   state_nxt = after_unit(state_r, ST_RED_D1, sts.done, sts.ovf);
      ST_RED_D1:  state_nxt = after_unit(state_r, ST_RED_D2, sts.done, sts.ovf);
      ST_RED_D2:  state_nxt = after_unit(state_r, ST_FINISH, sts.done, sts.ovf);
      ST_FINISH: begin
        if (!ov_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
    go_nxt = state_nxt != state_r;
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready     = state_r == ST_IDLE;
  assign out_valid    = ov_r;
  assign cmd.step     = state_r;
  assign cmd.go       = go_r;
  assign cmd.load_in  = in_ready && in_valid;
  assign cmd.load_out = load_out;

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_CHECK)
    else $error("accepted request did not enter check");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && state_nxt == ST_IDLE) |=> out_valid)
    else $error("finished request not presented");

  a_go_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> state_r != $past(state_r))
    else $error("unit start without state change");

endmodule

>>> verif/rau_checker.sv
// rau_checker: watches the request and result channels of rational_arithmetic_unit,
// predicts each result from the request fields and compares field by field
// depends on rau_pkg
`timescale 1ns / 1ps

module rau_checker #(
  parameter int WORD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rau_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rau_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count,
  output int            result_count
);
  import rau_pkg::*;

  localparam logic [127:0] WMASK = (128'd1 << WORD_BITS) - 128'd1;

  out_t expected_q[$];

  function automatic logic [127:0] gcd128(logic [127:0] x, logic [127:0] y);
    logic [127:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_t predict_rational(in_t req);
    out_t r;
    logic [127:0] an, ad, bn, bd, q, lim, g, den, sa, sb, num, p1, p2;
    logic aneg, bneg, neg, ovf, za, zb, sga, sgb;
    int c;
    r = '0;
    an = req.a_num & WMASK;
    ad = req.a_den & WMASK;
    bn = req.b_num & WMASK;
    bd = req.b_den & WMASK;
    aneg = req.a_neg;
    bneg = req.b_neg;
    ovf = 0;
    if (req.func == FN_INT) begin
      if (ad == 0) begin
        r.status = STAT_ZDEN;
      end else begin
        q = an / ad;
        lim = 128'd1 << (WORD_BITS - 1);
        if (aneg ? (q > lim) : (q >= lim)) begin
          r.status = STAT_OVF;
        end else begin
          r.int_value = aneg ? (64'd0 - q[63:0]) : q[63:0];
        end
      end
    end else if (ad == 0 || bd == 0) begin
      r.status = STAT_ZDEN;
    end else if (req.func == FN_CMP) begin
      za = an == 0;
      zb = bn == 0;
      sga = aneg && !za;
      sgb = bneg && !zb;
      if (za && zb) c = 0;
      else if (sga != sgb) c = sga ? -1 : 1;
      else begin
        p1 = an * bd;
        p2 = bn * ad;
        c = (p1 < p2) ? -1 : (p1 > p2) ? 1 : 0;
        if (sga) c = -c;
      end
      r.order = (c < 0) ? ORD_LT : (c == 0) ? ORD_EQ : ORD_GT;
    end else begin
      num = 0;
      den = 0;
      if (req.func == FN_ADD) begin
        g = gcd128(ad, bd);
        den = (ad / g) * bd;
        ovf = den > WMASK;
        if (!ovf) begin
          sa = an * (den / ad);
          sb = bn * (den / bd);
          ovf = sa > WMASK || sb > WMASK;
        end
        neg = aneg;
        if (!ovf) begin
          if (aneg == bneg) begin
            num = sa + sb;
            ovf = num > WMASK;
          end else if (sb > sa) begin
            num = sb - sa;
            neg = bneg;
          end else begin
            num = sa - sb;
          end
        end
      end else begin
        num = an * bn;
        den = ad * bd;
        ovf = num > WMASK || den > WMASK;
        neg = aneg != bneg;
      end
      if (ovf) begin
        r.status = STAT_OVF;
      end else begin
        g = gcd128(num, den);
        r.r_num = num / g;
        r.r_den = den / g;
        r.r_neg = neg && (r.r_num != 0);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && in_valid && in_ready) begin
      expected_q.push_back(predict_rational(in_data));
    end
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.r_num, 0);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.r_num !== exp_r.r_num)
          report_mismatch("r_num", out_data.r_num, exp_r.r_num);
        if (out_data.r_den !== exp_r.r_den)
          report_mismatch("r_den", out_data.r_den, exp_r.r_den);
        if (out_data.r_neg !== exp_r.r_neg)
          report_mismatch("r_neg", out_data.r_neg, exp_r.r_neg);
        if (out_data.order !== exp_r.order)
          report_mismatch("order", out_data.order, exp_r.order);
        if (out_data.int_value !== exp_r.int_value)
          report_mismatch("int_value", out_data.int_value, exp_r.int_value);
        if (out_data.status !== exp_r.status)
          report_mismatch("status", out_data.status, exp_r.status);
      end
    end
    pending_count = expected_q.size();
  end

endmodule

>>> verif/testbench.sv
// testbench: drives requests into rational_arithmetic_unit with random gaps and stalls
// and reports the verdict; depends on rau_pkg, rau_checker and the unit itself
`timescale 1ns / 1ps

module testbench;
  import rau_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  int fail_count, pending_count, result_count;
  int idle_cycles = 0;
  int sent = 0;

  always #6 clk = ~clk;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rau_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly small or structured operand values so sums and products stay in range
  function automatic logic [63:0] pick_value(bit allow_zero);
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = rand64();
      1: v = rand64() >> $urandom_range(1, 63);
      2: v = {$urandom()} & 32'hffff;
      3: v = $urandom_range(0, 12);
      4: v = 64'd1 << $urandom_range(0, 63);
      5: v = 64'hffff_ffff_ffff_ffff - $urandom_range(0, 3);
      default: v = {$urandom()} >> $urandom_range(0, 31);
    endcase
    if (v == 0 && !allow_zero && $urandom_range(0, 9) != 0) v = 1;
    return v;
  endfunction

  task automatic send_request(func_e_t f, logic [63:0] an, logic [63:0] ad, logic an_neg,
                              logic [63:0] bn, logic [63:0] bd, logic bn_neg);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{func: f, a_num: an, a_den: ad, a_neg: an_neg,
                 b_num: bn, b_den: bd, b_neg: bn_neg};
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    func_e_t f;
    logic [63:0] ad, bd;
    f = func_e_t'($urandom_range(0, 3));
    ad = pick_value(0);
    bd = ($urandom_range(0, 4) == 0) ? ad : pick_value(0);
    send_request(f, pick_value(1), ad, $urandom_range(0, 1),
                 pick_value(1), bd, $urandom_range(0, 1));
  endtask

  // result side: random stall before each result, sometimes none
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d requests", sent);
      $display("[rational_arithmetic_unit] ERROR");
      $finish;
    end
  end

  localparam logic [63:0] MAXV = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MINI = 64'h8000_0000_0000_0000;

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    send_request(FN_ADD, 1, 2, 0, 1, 3, 0);
    send_request(FN_ADD, 1, 2, 0, 1, 2, 1);
    send_request(FN_ADD, 3, 4, 1, 1, 6, 0);
    send_request(FN_ADD, MAXV, 1, 0, 1, 1, 0);
    send_request(FN_ADD, 1, MAXV, 0, 1, MAXV - 1, 0);
    send_request(FN_ADD, 1, 0, 0, 1, 1, 0);
    send_request(FN_MUL, 2, 3, 1, 3, 4, 0);
    send_request(FN_MUL, 0, 5, 1, 7, 9, 0);
    send_request(FN_MUL, MAXV, 1, 0, 2, 1, 0);
    send_request(FN_MUL, 1, MAXV, 1, 1, 3, 1);
    send_request(FN_MUL, 1, 1, 0, 1, 0, 0);
    send_request(FN_CMP, 0, 1, 1, 0, 7, 0);
    send_request(FN_CMP, 1, 3, 0, 2, 6, 0);
    send_request(FN_CMP, 1, 3, 1, 1, 2, 1);
    send_request(FN_CMP, MAXV, 1, 0, MAXV, 2, 0);
    send_request(FN_CMP, 5, 1, 1, 1, 1, 0);
    send_request(FN_CMP, 1, 0, 0, 1, 1, 0);
    send_request(FN_INT, 7, 2, 1, 0, 0, 0);
    send_request(FN_INT, MINI, 1, 1, 0, 0, 0);
    send_request(FN_INT, MINI, 1, 0, 0, 0, 0);
    send_request(FN_INT, MINI - 1, 1, 0, MAXV, MAXV, 1);
    send_request(FN_INT, MAXV, 0, 0, 0, 0, 0);
    send_request(FN_INT, 0, MAXV, 1, 0, 0, 0);
    repeat (RANDOM_ITEMS) send_random();
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d requests over all four operations, %0d results checked",
             sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[rational_arithmetic_unit] OK");
    end else begin
      $display("[rational_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rau_pkg.sv
rtl/core/rau_div.sv
rtl/core/rau_mul.sv
rtl/core/rau_dp.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
verif/rau_checker.sv
verif/testbench.sv
